// ----- design/welex_pkg.sv -----
// shared constants, types and codes for the window extreme level estimator
`default_nettype none

package welex_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int RANK_DEPTH     = 5;
    localparam int COUNT_BITS     = 16;
    localparam int TRIM_THRESHOLD = 13;

    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // sum of three samples needs two guard bits
    localparam int SUM_BITS   = SAMPLE_BITS + 2;
    localparam int DIV3_SHIFT = SAMPLE_BITS + 2;
    localparam int PROD_BITS  = SUM_BITS + DIV3_SHIFT;
    localparam logic [DIV3_SHIFT-1:0] DIV3_MULT =
        DIV3_SHIFT'(((66'd1 << DIV3_SHIFT) + 66'd2) / 66'd3);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic [COUNT_BITS-1:0]         t_count;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_count  COUNT_MAX  = '1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SUM,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        AVG_ONE,
        AVG_TWO,
        AVG_THREE
    } t_avg_mode;

    typedef struct packed {
        logic ready;  // sample stream open
        logic sum;    // form sums, clear window state
        logic mul;    // scale sums by one third
        logic load;   // write result register
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- design/welex_ctrl.sv -----
// controller state machine: window intake and end-of-window result sequence
`default_nettype none

module welex_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic                  i_last,
    input  wire welex_pkg::t_dp_status i_status,
    output welex_pkg::t_ctrl_cmd       o_cmd
);
    import welex_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (i_accept && i_last) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: n_state = ST_MUL;
            ST_MUL: n_state = ST_FIN;
            ST_FIN: begin
                if (i_status.out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_RUN: o_cmd.ready = 1'b1;
            ST_SUM: o_cmd.sum   = 1'b1;
            ST_MUL: o_cmd.mul   = 1'b1;
            ST_FIN: o_cmd.load  = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    a_sum_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |=> (r_state == ST_MUL))
        else $error("sum step not followed by multiply step");

    a_last_starts_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_state == ST_SUM))
        else $error("last sample did not start the result sequence");

endmodule

`default_nettype wire

// ----- design/welex_dp.sv -----
// datapath: rank insertion, sample count, trimmed means and result register
`default_nettype none

module welex_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire welex_pkg::t_sample       i_sample,
    input  wire welex_pkg::t_ctrl_cmd     i_cmd,
    input  wire logic                     i_out_ready,
    output welex_pkg::t_dp_status         o_status,
    output logic                          o_out_valid,
    output welex_pkg::t_sample            o_low_level,
    output welex_pkg::t_sample            o_high_level
);
    import welex_pkg::*;

    t_sample   r_low  [RANK_DEPTH];
    t_sample   r_high [RANK_DEPTH];
    t_sample   n_low  [RANK_DEPTH];
    t_sample   n_high [RANK_DEPTH];
    t_count    r_count;
    logic      [RANK_DEPTH-1:0] lt;
    logic      [RANK_DEPTH-1:0] gt;

    t_sum      r_lo_sum;
    t_sum      r_hi_sum;
    t_sum      n_lo_sum;
    t_sum      n_hi_sum;
    t_avg_mode r_mode;
    t_avg_mode n_mode;
    logic      [PROD_BITS-1:0] r_lo_prod;
    logic      [PROD_BITS-1:0] r_hi_prod;
    logic      [SUM_BITS-1:0]  lo_mag;
    logic      [SUM_BITS-1:0]  hi_mag;

    logic      r_out_valid;
    t_sample   r_low_level;
    t_sample   r_high_level;
    t_sample   n_low_level;
    t_sample   n_high_level;
    logic      ranks_sorted;

    // compare-and-shift insertion, strict comparison
    always_comb begin
        for (int i = 0; i < RANK_DEPTH; i++) begin
            lt[i] = i_sample < r_low[i];
            gt[i] = i_sample > r_high[i];
        end
        for (int i = 0; i < RANK_DEPTH; i++) begin
            n_low[i]  = lt[i] ? i_sample : r_low[i];
            n_high[i] = gt[i] ? i_sample : r_high[i];
        end
        // entries past the insertion point move down one place
        for (int i = 1; i < RANK_DEPTH; i++) begin
            if (lt[i-1]) begin
                n_low[i] = r_low[i-1];
            end
            if (gt[i-1]) begin
                n_high[i] = r_high[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sum) begin
            for (int i = 0; i < RANK_DEPTH; i++) begin
                r_low[i]  <= SAMPLE_MAX;
                r_high[i] <= SAMPLE_MIN;
            end
            r_count <= '0;
        end else if (i_accept) begin
            for (int i = 0; i < RANK_DEPTH; i++) begin
                r_low[i]  <= n_low[i];
                r_high[i] <= n_high[i];
            end
            if (r_count != COUNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // level selection by window length
    always_comb begin
        if (r_count == t_count'(1)) begin
            n_mode   = AVG_ONE;
            n_lo_sum = SUM_BITS'(r_low[0]);
            n_hi_sum = SUM_BITS'(r_low[0]);
        end else if (r_count == t_count'(2)) begin
            n_mode   = AVG_TWO;
            n_lo_sum = SUM_BITS'(r_low[0]) + SUM_BITS'(r_high[0]);
            n_hi_sum = n_lo_sum;
        end else if (r_count >= t_count'(TRIM_THRESHOLD)) begin
            n_mode   = AVG_THREE;
            n_lo_sum = SUM_BITS'(r_low[2]) + SUM_BITS'(r_low[3]) + SUM_BITS'(r_low[4]);
            n_hi_sum = SUM_BITS'(r_high[2]) + SUM_BITS'(r_high[3])
                     + SUM_BITS'(r_high[4]);
        end else begin
            n_mode   = AVG_THREE;
            n_lo_sum = SUM_BITS'(r_low[0]) + SUM_BITS'(r_low[1]) + SUM_BITS'(r_low[2]);
            n_hi_sum = SUM_BITS'(r_high[0]) + SUM_BITS'(r_high[1])
                     + SUM_BITS'(r_high[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_lo_sum <= n_lo_sum;
            r_hi_sum <= n_hi_sum;
            r_mode   <= n_mode;
        end
    end

    // divide by three on the magnitude: multiply by reciprocal, sign restored later
    assign lo_mag = r_lo_sum[SUM_BITS-1] ? SUM_BITS'(-r_lo_sum) : SUM_BITS'(r_lo_sum);
    assign hi_mag = r_hi_sum[SUM_BITS-1] ? SUM_BITS'(-r_hi_sum) : SUM_BITS'(r_hi_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_lo_prod <= PROD_BITS'(lo_mag) * PROD_BITS'(DIV3_MULT);
            r_hi_prod <= PROD_BITS'(hi_mag) * PROD_BITS'(DIV3_MULT);
        end
    end

    function automatic t_sample finish_mean(input t_avg_mode mode, input t_sum s,
                                            input logic [PROD_BITS-1:0] prod);
        t_sample q;
        t_sum    half;
        begin
            q    = t_sample'(prod[PROD_BITS-1:DIV3_SHIFT]);
            half = (s + t_sum'(s[SUM_BITS-1])) >>> 1;
            case (mode)
                AVG_ONE: finish_mean = s[SAMPLE_BITS-1:0];
                AVG_TWO: finish_mean = half[SAMPLE_BITS-1:0];
                default: finish_mean = s[SUM_BITS-1] ? -q : q;
            endcase
        end
    endfunction

    assign n_low_level  = finish_mean(r_mode, r_lo_sum, r_lo_prod);
    assign n_high_level = finish_mean(r_mode, r_hi_sum, r_hi_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_low_level  <= n_low_level;
            r_high_level <= n_high_level;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_low_level       = r_low_level;
    assign o_high_level      = r_high_level;

    always_comb begin
        ranks_sorted = 1'b1;
        for (int i = 0; i < RANK_DEPTH - 1; i++) begin
            if (r_low[i] > r_low[i+1] || r_high[i] < r_high[i+1]) begin
                ranks_sorted = 1'b0;
            end
        end
    end

    a_ranks_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ranks_sorted)
        else $error("rank lists out of order");

    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum |=> (r_count == '0))
        else $error("window state not cleared after result");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transaction");

    a_no_intake_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum |-> !i_accept)
        else $error("sample taken during result sequence");

endmodule

`default_nettype wire

// ----- design/window_extreme_level_estimator.sv -----
// top level: stream ports around the controller and the datapath
//
// Slave stream carries one signed sample per transaction (tdata) and tlast on
// the final sample of a window. The block keeps the five smallest and five
// largest samples of the window and a saturating sample count. After the
// last sample it sends one master-stream transaction with the low level in
// the lower half of tdata and the high level in the upper half.
// Throughput: one sample per cycle within a window. At the end of a window
// the slave side closes for the three-step result sequence (sum, multiply by
// one third, result load); the result is on o_m_tvalid after the load step,
// which waits while a previous result is still pending.
// The result register parts the two sides: a new window streams in while a
// result waits. If the receiver still stalls when the next window ends, the
// slave side stays closed until the waiting result is taken.
// Reset (synchronous, active low) empties the window and drops any pending
// result.
`default_nettype none

module window_extreme_level_estimator (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [welex_pkg::S_TDATA_BITS-1:0]   i_s_tdata,  // sample
    input  wire logic                                 i_s_tlast,  // last_sample
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic [welex_pkg::M_TDATA_BITS-1:0]        o_m_tdata   // low_level, high_level
);
    import welex_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       in_accept;
    t_sample    low_level;
    t_sample    high_level;

    assign o_s_tready = cmd.ready;
    assign in_accept  = i_s_tvalid && cmd.ready;

    welex_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_last   (i_s_tlast),
        .i_status (status),
        .o_cmd    (cmd)
    );

    welex_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_sample     (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_cmd        (cmd),
        .i_out_ready  (i_m_tready),
        .o_status     (status),
        .o_out_valid  (o_m_tvalid),
        .o_low_level  (low_level),
        .o_high_level (high_level)
    );

    assign o_m_tdata = M_TDATA_BITS'({high_level, low_level});

endmodule

`default_nettype wire
